/* rtl/psrl_pkg.sv */
// Package for the per-source rate limiter: table entry layout, codes,
// configuration defaults and the controller/datapath handshake structs.
// No dependencies.
package psrl_pkg;

  // Table geometry
  localparam int TABLE_INDEX_BITS = 10;
  localparam int TABLE_DEPTH      = 1 << TABLE_INDEX_BITS;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Window and ban arithmetic
  localparam logic [31:0] WINDOW_MS = 32'd1000;
  localparam logic [31:0] MS_PER_S  = 32'd1000;

  // Register reset values
  localparam logic [23:0] PACKET_LIMIT_RST     = 24'd1000;
  localparam logic [23:0] CONNECTION_LIMIT_RST = 24'd100;
  localparam logic [31:0] BYTE_LIMIT_RST       = 32'd1048576;
  localparam logic [20:0] BAN_SECONDS_RST      = 21'd3600;

  typedef enum logic [1:0] {
    CMD_PACKET    = 2'd0,
    CMD_CONN      = 2'd1,
    CMD_WHITELIST = 2'd2,
    CMD_IGNORED   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RSN_NONE        = 3'd0,
    RSN_BLACKLISTED = 3'd1,
    RSN_PACKETS     = 3'd2,
    RSN_BYTES       = 3'd3,
    RSN_CONNS       = 3'd4
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PACKET_LIMIT     = 2'd0,
    CFG_CONNECTION_LIMIT = 2'd1,
    CFG_BYTE_LIMIT       = 2'd2,
    CFG_BAN_SECONDS      = 2'd3
  } cfg_idx_t;

  // One table entry, held as a single memory word
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic        trusted;
    logic        banned;
    logic [31:0] ban_until;
    logic [31:0] wstart;
    logic [24:0] pkts;
    logic [32:0] bytes;
    logic [24:0] conns;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic                        clear;
    logic [TABLE_INDEX_BITS-1:0] clear_addr;
    logic                        accept;
    logic                        eval;
    logic                        update;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_stall;
  } dp_sts_t;

endpackage

/* rtl/per_source_rate_limiter.sv */
// Per-source flood filter. After reset the table is cleared in a pass of
// one entry per cycle over all 2^TABLE_INDEX_BITS entries, during
// which no beat is accepted; configuration writes are taken at any time the
// block is idle. Each beat then goes through 3 steps: accept and table read, entry
// evaluation, update and write back, set by the read-modify-write of the
// table memory, whose read data is registered. One beat is in flight at a
// time; a result held in the output register stalls the update step until
// it is taken.
// Uses psrl_pkg, psrl_ctrl, psrl_dp, psrl_ram.
module per_source_rate_limiter import psrl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [31:0] source_ip, [48:32] packet_bytes, [80:49] now_ms, rest zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [1:0] command
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] allowed, [3:1] block_reason, [4] newly_banned, [5] entry_replaced
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  psrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psrl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* rtl/psrl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/psrl_ctrl.sv */
// Controller for the rate limiter: clearing pass after reset, then the
// accept / evaluate / update sequence for each beat. Uses psrl_pkg.
module psrl_ctrl import psrl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_UPDATE
  } state_t;

  state_t                      state;
  logic                        ready;
  logic [TABLE_INDEX_BITS-1:0] clr_addr;

  // Commands to the datapath
  assign cmd.clear      = (state == ST_CLEAR);
  assign cmd.clear_addr = clr_addr;
  assign cmd.accept     = ready && s_tvalid;
  assign cmd.eval       = (state == ST_EVAL);
  assign cmd.update     = (state == ST_UPDATE) && !sts.out_stall;
  assign s_tready       = ready;

  // State and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ready    <= 1'b0;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= ST_IDLE;
            ready <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EVAL;
            ready <= 1'b0;
          end
        end
        ST_EVAL: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (!sts.out_stall) begin
            state <= ST_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= ST_CLEAR;
          ready <= 1'b0;
        end
      endcase
    end
  end

  // Ready only while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    ready == (state == ST_IDLE))
    else $error("ready out of step with idle state");

  // An accepted beat goes straight to evaluation
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == ST_EVAL))
    else $error("accepted beat did not move to evaluation");

  // No beat taken while the table is being cleared
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !cmd.accept && !cmd.update)
    else $error("table access during clearing pass");

endmodule

/* rtl/psrl_dp.sv */
// Datapath for the rate limiter: config registers, table RAM, entry
// evaluation and update, output register. Uses psrl_pkg and psrl_ram.
module psrl_dp import psrl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_cmd_t               cmd,
  output dp_sts_t                sts,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration
  logic [23:0] packet_limit;
  logic [23:0] connection_limit;
  logic [31:0] byte_limit;
  logic [20:0] ban_seconds;
  logic [31:0] ban_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_limit     <= PACKET_LIMIT_RST;
      connection_limit <= CONNECTION_LIMIT_RST;
      byte_limit       <= BYTE_LIMIT_RST;
      ban_seconds      <= BAN_SECONDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PACKET_LIMIT:     packet_limit     <= cfg_data[23:0];
        CFG_CONNECTION_LIMIT: connection_limit <= cfg_data[23:0];
        CFG_BYTE_LIMIT:       byte_limit       <= cfg_data[31:0];
        CFG_BAN_SECONDS:      ban_seconds      <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  // Ban length in ms, recomputed every cycle (the user must keep config static while busy, unenforced by the block)
  always_ff @(posedge clk) begin
    ban_ms <= 32'(32'(ban_seconds) * MS_PER_S);
  end

  // Beat capture
  cmd_t        it_cmd;
  logic [31:0] it_ip;
  logic [16:0] it_len;
  logic [31:0] it_now;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_cmd <= cmd_t'(s_tuser);
      it_ip  <= s_tdata[31:0];
      it_len <= s_tdata[48:32];
      it_now <= s_tdata[80:49];
    end
  end

  // Table memory
  logic                        ram_we;
  logic [TABLE_INDEX_BITS-1:0] ram_waddr;
  logic [ENTRY_W-1:0]          ram_wdata;
  logic [ENTRY_W-1:0]          ram_rdata;
  entry_t                      upd;

  assign ram_we    = cmd.clear || (cmd.update && (it_cmd != CMD_IGNORED));
  assign ram_waddr = cmd.clear ? cmd.clear_addr : it_ip[TABLE_INDEX_BITS-1:0];
  assign ram_wdata = cmd.clear ? '0 : upd;

  psrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (s_tdata[TABLE_INDEX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // Evaluate: tag check / refill, ban expiry, window roll
  entry_t      rd;
  entry_t      base;
  entry_t      ev_next;
  logic        hit;
  logic [31:0] left;
  logic [31:0] elapsed;
  logic        still;
  logic        roll;
  logic        blocked;

  always_comb begin
    rd   = entry_t'(ram_rdata);
    hit  = rd.valid && (rd.tag == it_ip);
    base = rd;
    if (!hit) begin
      base        = '0;
      base.valid  = 1'b1;
      base.tag    = it_ip;
      base.wstart = it_now;
    end
    left    = base.ban_until - it_now;
    still   = base.banned && (left != '0) && !left[31];
    elapsed = it_now - base.wstart;
    roll    = (elapsed >= WINDOW_MS);
    ev_next = base;
    blocked = 1'b0;
    if (it_cmd == CMD_WHITELIST) begin
      ev_next.trusted = 1'b1;
      ev_next.banned  = 1'b0;
    end else if (still) begin
      blocked = 1'b1;
    end else begin
      ev_next.banned = 1'b0;
      if (roll) begin
        ev_next.pkts   = '0;
        ev_next.bytes  = '0;
        ev_next.conns  = '0;
        ev_next.wstart = it_now;
      end
    end
  end

  entry_t ev_entry;
  logic   ev_blocked;
  logic   ev_replaced;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ev_entry    <= ev_next;
      ev_blocked  <= blocked;
      ev_replaced <= rd.valid && !hit;
    end
  end

  // Update: saturating counts, limit checks, ban
  logic [24:0] pk_inc;
  logic [24:0] cn_inc;
  logic [33:0] bsum;
  logic [32:0] bsat;
  reason_t     reason;
  logic        allowed;
  logic        banned_now;

  always_comb begin
    pk_inc     = (&ev_entry.pkts) ? ev_entry.pkts : ev_entry.pkts + 25'd1;
    cn_inc     = (&ev_entry.conns) ? ev_entry.conns : ev_entry.conns + 25'd1;
    bsum       = 34'(ev_entry.bytes) + 34'(it_len);
    bsat       = bsum[33] ? '1 : bsum[32:0];
    upd        = ev_entry;
    reason     = RSN_NONE;
    allowed    = 1'b1;
    banned_now = 1'b0;
    unique case (it_cmd)
      CMD_WHITELIST: begin
        allowed = 1'b1;
      end
      CMD_IGNORED: begin
        allowed = 1'b0;
      end
      CMD_PACKET, CMD_CONN: begin
        if (ev_blocked) begin
          reason = RSN_BLACKLISTED;
        end else begin
          if (it_cmd == CMD_PACKET) begin
            upd.pkts  = pk_inc;
            upd.bytes = bsat;
            if (!ev_entry.trusted) begin
              if (pk_inc > {1'b0, packet_limit}) begin
                reason = RSN_PACKETS;
              end else if (bsat > {1'b0, byte_limit}) begin
                reason = RSN_BYTES;
              end
            end
          end else begin
            upd.conns = cn_inc;
            if (!ev_entry.trusted && (cn_inc > {1'b0, connection_limit})) begin
              reason = RSN_CONNS;
            end
          end
          if (reason != RSN_NONE) begin
            upd.banned    = 1'b1;
            upd.ban_until = it_now + ban_ms;
            banned_now    = 1'b1;
          end
        end
        allowed = (reason == RSN_NONE);
      end
      default: begin
        allowed = 1'b0;
      end
    endcase
  end

  // Output register: allowed, reason, newly banned, replaced
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      m_tdata <= {2'b00, ev_replaced && (it_cmd != CMD_IGNORED), banned_now,
                  reason, allowed};
    end
  end

  assign sts.out_stall = m_tvalid && !m_tready;

  // Never overwrite a beat that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // An allowed beat carries no reason
  a_allowed_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[3:1] == RSN_NONE) && !m_tdata[4])
    else $error("allowed beat with block reason");

  // A fresh ban always names a limit
  a_ban_reason: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> (m_tdata[3:1] == RSN_PACKETS) ||
      (m_tdata[3:1] == RSN_BYTES) || (m_tdata[3:1] == RSN_CONNS))
    else $error("new ban without a limit reason");

endmodule

/* tb/per_source_rate_limiter_tb.sv */
// Testbench for per_source_rate_limiter: drives command beats and register writes,
// predicts every verdict with its own per-source table and checks each output beat.
// Depends on psrl_pkg and the per_source_rate_limiter RTL.
`timescale 1ns / 100ps

module per_source_rate_limiter_tb import psrl_pkg::*; ();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_TICKS = 16;

  // Predicted state of one table slot
  typedef struct {
    logic        valid;
    logic [31:0] tag;
    logic        trusted;
    logic        banned;
    logic [31:0] ban_until;
    logic [31:0] wstart;
    logic [24:0] pkts;
    logic [32:0] bytes;
    logic [24:0] conns;
  } src_rec_t;

  // One verdict as it leaves the block
  typedef struct {
    logic    allowed;
    reason_t reason;
    logic    newly_banned;
    logic    replaced;
  } verdict_t;

  // Flood-filter predictor plus the queue of verdicts still owed by the block
  class verdict_board;
    src_rec_t    slot[TABLE_DEPTH];
    verdict_t    verdicts_due[$];
    logic [31:0] pkt_limit;
    logic [31:0] conn_limit;
    logic [31:0] byte_limit;
    logic [31:0] ban_secs;
    int          fails;

    function new();
      pkt_limit  = 32'(PACKET_LIMIT_RST);
      conn_limit = 32'(CONNECTION_LIMIT_RST);
      byte_limit = BYTE_LIMIT_RST;
      ban_secs   = 32'(BAN_SECONDS_RST);
      fails      = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot[i] = '{valid: 1'b0, tag: '0, trusted: 1'b0, banned: 1'b0, ban_until: '0,
                    wstart: '0, pkts: '0, bytes: '0, conns: '0};
      end
    endfunction

    function void set_register(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_PACKET_LIMIT:     pkt_limit  = {8'd0, val[23:0]};
        CFG_CONNECTION_LIMIT: conn_limit = {8'd0, val[23:0]};
        CFG_BYTE_LIMIT:       byte_limit = val;
        CFG_BAN_SECONDS:      ban_secs   = {11'd0, val[20:0]};
        default: ;
      endcase
    endfunction

    function int outstanding();
      return verdicts_due.size();
    endfunction

    // Work out the verdict of one accepted beat and advance the table
    function void note_beat(cmd_t cmd, logic [31:0] ip, logic [16:0] len, logic [31:0] now);
      logic [TABLE_INDEX_BITS-1:0] idx;
      src_rec_t    rec;
      verdict_t    v;
      logic [31:0] left;
      logic [31:0] age;
      logic [33:0] sum;
      v = '{allowed: 1'b1, reason: RSN_NONE, newly_banned: 1'b0, replaced: 1'b0};
      if (cmd == CMD_IGNORED) begin
        v.allowed = 1'b0;
        verdicts_due.push_back(v);
        return;
      end
      idx = ip[TABLE_INDEX_BITS-1:0];
      rec = slot[idx];
      // tag miss: evict and start fresh
      if (!rec.valid || rec.tag != ip) begin
        v.replaced = rec.valid;
        rec = '{valid: 1'b1, tag: ip, trusted: 1'b0, banned: 1'b0, ban_until: '0,
                wstart: now, pkts: '0, bytes: '0, conns: '0};
      end
      if (cmd == CMD_WHITELIST) begin
        rec.trusted = 1'b1;
        rec.banned  = 1'b0;
      end else begin
        left = rec.ban_until - now;
        if (rec.banned && left != 32'd0 && !left[31]) begin
          v.allowed = 1'b0;
          v.reason  = RSN_BLACKLISTED;
        end else begin
          rec.banned = 1'b0;
          age = now - rec.wstart;
          if (age >= WINDOW_MS) begin
            rec.pkts   = '0;
            rec.bytes  = '0;
            rec.conns  = '0;
            rec.wstart = now;
          end
          if (cmd == CMD_PACKET) begin
            if (rec.pkts != '1) rec.pkts = rec.pkts + 25'd1;
            sum = {1'b0, rec.bytes} + {17'd0, len};
            rec.bytes = sum[33] ? '1 : sum[32:0];
            if (!rec.trusted) begin
              if ({7'd0, rec.pkts} > pkt_limit) v.reason = RSN_PACKETS;
              else if (rec.bytes > {1'b0, byte_limit}) v.reason = RSN_BYTES;
            end
          end else begin
            if (rec.conns != '1) rec.conns = rec.conns + 25'd1;
            if (!rec.trusted && {7'd0, rec.conns} > conn_limit) v.reason = RSN_CONNS;
          end
          if (v.reason != RSN_NONE) begin
            rec.banned       = 1'b1;
            rec.ban_until    = now + ban_secs * MS_PER_S;
            v.allowed        = 1'b0;
            v.newly_banned   = 1'b1;
          end
        end
      end
      slot[idx] = rec;
      verdicts_due.push_back(v);
    endfunction

    // Compare one output beat against the oldest owed verdict
    function void check_verdict(logic [OUT_TDATA_W-1:0] bits);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("verdict beat 0x%0h arrived with nothing expected", bits);
        fails++;
        return;
      end
      want = verdicts_due.pop_front();
      if (bits[0] !== want.allowed) begin
        $error("allowed: expected %0d, got %0d", want.allowed, bits[0]);
        fails++;
      end
      if (bits[3:1] !== want.reason) begin
        $error("block_reason: expected %0d, got %0d", want.reason, bits[3:1]);
        fails++;
      end
      if (bits[4] !== want.newly_banned) begin
        $error("newly_banned: expected %0d, got %0d", want.newly_banned, bits[4]);
        fails++;
      end
      if (bits[5] !== want.replaced) begin
        $error("entry_replaced: expected %0d, got %0d", want.replaced, bits[5]);
        fails++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [31:0] source_ip, [48:32] packet_bytes, [80:49] now_ms
  logic [IN_TUSER_W-1:0]  s_tuser;   // [1:0] command
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [0] allowed, [3:1] reason, [4] newly_banned, [5] replaced
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  verdict_board sb;
  logic         tx_idle;
  logic         rx_idle;
  logic         hold_req;
  logic         rst_done;
  logic [31:0]  clock_ms;
  logic [31:0]  src_pool[16];
  int           cycle_count;

  per_source_rate_limiter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Global watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Output side: random stalls, one long hold-off on request
  initial begin
    int wait_cycles;
    m_tready = 1'b0;
    wait (rst_done);
    forever begin
      wait_cycles = rx_idle ? $urandom_range(0, 15) : 0;
      if (hold_req) begin
        hold_req    = 1'b0;
        wait_cycles = HOLD_CYCLES;
      end
      if (wait_cycles != 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (wait_cycles - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_verdict(m_tdata);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_register(idx, val);
  endtask

  task automatic set_limits(logic [31:0] pl, logic [31:0] cl, logic [31:0] bl, logic [31:0] bs);
    write_reg(CFG_PACKET_LIMIT, pl);
    write_reg(CFG_CONNECTION_LIMIT, cl);
    write_reg(CFG_BYTE_LIMIT, bl);
    write_reg(CFG_BAN_SECONDS, bs);
  endtask

  // Offer one beat and hold it until taken, then an optional gap
  task automatic send_beat(cmd_t cmd, logic [31:0] ip, logic [16:0] len, logic [31:0] now);
    logic [IN_TDATA_W-1:0] bits;
    int gap;
    bits       = '0;
    bits[80:0] = {now, len, ip};
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= bits;
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_beat(cmd, ip, len, now);
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait for every owed verdict, then let the pipe empty
  task automatic quiesce();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Random traffic over a small source pool, with index collisions and repeats
  task automatic run_random(int n_items);
    int          r;
    cmd_t        c;
    logic [31:0] ip;
    logic [31:0] last_ip;
    logic [16:0] len;
    for (int k = 0; k < 16; k++) begin
      src_pool[k] = $urandom;
      if (k % 2 == 1) src_pool[k][TABLE_INDEX_BITS-1:0] = src_pool[k-1][TABLE_INDEX_BITS-1:0];
    end
    last_ip  = src_pool[0];
    clock_ms = $urandom;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      c = r < 55 ? CMD_PACKET : r < 85 ? CMD_CONN : r < 95 ? CMD_WHITELIST : CMD_IGNORED;
      r = $urandom_range(0, 99);
      ip = r < 30 ? last_ip : r < 85 ? src_pool[$urandom_range(0, 15)] : $urandom;
      r = $urandom_range(0, 99);
      len = r < 10 ? 17'd0 : r < 20 ? 17'd65536 : 17'($urandom_range(0, 65536));
      // mostly short steps, some window rolls, rare far jumps either way
      r = $urandom_range(0, 99);
      if (r < 70)      clock_ms = clock_ms + $urandom_range(0, 40);
      else if (r < 90) clock_ms = clock_ms + $urandom_range(200, 1200);
      else if (r < 97) clock_ms = clock_ms + $urandom_range(1000, 5000);
      else             clock_ms = $urandom;
      send_beat(c, ip, len, clock_ms);
      last_ip = ip;
    end
  endtask

  initial begin
    logic [31:0] ip_a;
    logic [31:0] t0;
    sb        = new();
    rst       = 1'b1;
    rst_done  = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    hold_req  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    rst_done = 1'b1;

    // Directed: tight limits, window and ban edges near the time wrap
    set_limits(32'd2, 32'd1, 32'd70000, 32'd1);
    ip_a = 32'hC0A8_0001;
    t0   = 32'hFFFF_FE00;
    send_beat(CMD_PACKET, ip_a, 17'd0, t0);
    send_beat(CMD_PACKET, ip_a, 17'd65536, t0 + 32'd1);
    send_beat(CMD_PACKET, ip_a, 17'd10, t0 + 32'd2);          // packet limit trips
    send_beat(CMD_CONN, ip_a, 17'd0, t0 + 32'd3);             // still banned
    send_beat(CMD_PACKET, ip_a, 17'd1, t0 + 32'd1002);        // ban ends exactly, window rolls
    send_beat(CMD_WHITELIST, ip_a, 17'd0, t0 + 32'd1003);
    send_beat(CMD_PACKET, ip_a, 17'd65536, t0 + 32'd1003);    // trusted: never banned
    send_beat(CMD_PACKET, ip_a, 17'd65536, t0 + 32'd1003);
    send_beat(CMD_PACKET, ip_a, 17'd65536, t0 + 32'd1004);
    send_beat(CMD_CONN, ip_a + 32'd1024, 17'd0, t0 + 32'd1005); // evicts a
    send_beat(CMD_CONN, ip_a + 32'd1024, 17'd0, t0 + 32'd1006); // connection limit
    send_beat(CMD_PACKET, 32'h0A00_0305, 17'd65536, 32'd5);
    send_beat(CMD_PACKET, 32'h0A00_0305, 17'd65536, 32'd6);    // byte limit
    send_beat(CMD_IGNORED, 32'hFFFF_FFFF, 17'd65536, 32'hFFFF_FFFF);
    send_beat(CMD_WHITELIST, 32'h0A00_0306, 17'd0, 32'd7);     // whitelist on a miss
    quiesce();

    // Zero limits, zero-length ban
    set_limits(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_beat(CMD_PACKET, 32'd0, 17'd0, 32'd0);
    send_beat(CMD_PACKET, 32'd0, 17'd0, 32'd0);                // ban already over
    send_beat(CMD_CONN, 32'hFFFF_FFFF, 17'd0, 32'd100);
    send_beat(CMD_WHITELIST, 32'hFFFF_FFFF, 17'd0, 32'd101);
    send_beat(CMD_CONN, 32'hFFFF_FFFF, 17'd0, 32'd102);
    quiesce();

    // Maximum limits and a long ban, tripped by the byte limit at zero
    set_limits(32'h00FF_FFFF, 32'h00FF_FFFF, 32'd0, 32'd2000000);
    send_beat(CMD_PACKET, 32'h5555_AAAA, 17'd0, 32'd1000);
    send_beat(CMD_PACKET, 32'h5555_AAAA, 17'd1, 32'd1001);
    send_beat(CMD_CONN, 32'h5555_AAAA, 17'd0, 32'd1001 + 32'd1999999999);
    send_beat(CMD_CONN, 32'h5555_AAAA, 17'd0, 32'd1001 + 32'd2000000000);
    send_beat(CMD_PACKET, 32'hAAAA_5555, 17'd65536, 32'h8000_0000);
    quiesce();

    // Random phases under different settings and flow control
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        3:       set_limits(32'd1000, 32'd100, 32'd1048576, 32'd3600);
        4:       set_limits({8'd0, 24'($urandom)}, {8'd0, 24'($urandom)}, $urandom,
                            32'($urandom_range(0, 2000000)));
        2:       set_limits($urandom_range(0, 2), $urandom_range(0, 1),
                            $urandom_range(0, 70000), 32'd1);
        default: set_limits($urandom_range(1, 6), $urandom_range(0, 4),
                            $urandom_range(20000, 200000), $urandom_range(0, 2));
      endcase
      tx_idle = (ph % 3 != 1);
      rx_idle = (ph % 3 == 0) || (ph == 5);
      // long output stall while the input keeps pushing
      if (ph == 1) hold_req = 1'b1;
      run_random(65);
      quiesce();
    end

    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/psrl_pkg.sv
rtl/psrl_ram.sv
rtl/psrl_ctrl.sv
rtl/psrl_dp.sv
rtl/per_source_rate_limiter.sv
tb/per_source_rate_limiter_tb.sv
